### rtl/utf8d_pkg.sv
`default_nettype none

package utf8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;

   // Byte classes of the UTF-8 encoding.
   localparam logic [BYTE_W-1:0] CONT_BASE  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_BASE = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_BASE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_BASE = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD_LIMIT = 8'hF8;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;

   localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

   // Pending continuation byte counts.
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_ONE   = 2'd1;
   localparam logic [1:0] PEND_TWO   = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            is_error;
      logic            last;
   } rsp_item_type;

   // Up to two results produced by one input byte.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

endpackage

`default_nettype wire

### rtl/utf8d_req_if.sv
`default_nettype none

interface utf8d_req_if;
   import utf8d_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

### rtl/utf8d_rsp_if.sv
`default_nettype none

interface utf8d_rsp_if;
   import utf8d_pkg::*;

   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            is_error;
   logic            last;

   modport source (output valid, output code_point, output is_error, output last, input ready);
   modport sink (input valid, input code_point, input is_error, input last, output ready);
endinterface

`default_nettype wire

### rtl/utf8d_decode.sv
`default_nettype none

module utf8d_decode (
   input  wire logic [utf8d_pkg::BYTE_W-1:0] in_byte,
   input  wire logic [1:0]                   pending,
   input  wire logic [utf8d_pkg::CP_W-1:0]   partial,
   output utf8d_pkg::rsp_push_type           push,
   output logic [1:0]                        pending_in,
   output logic [utf8d_pkg::CP_W-1:0]        partial_in
);
   import utf8d_pkg::*;

   rsp_item_type    fresh_item;
   rsp_item_type    error_item;
   logic            fresh_emit;
   logic [1:0]      fresh_pending;
   logic [CP_W-1:0] fresh_partial;
   logic            is_cont;
   logic [CP_W-1:0] joined;

   // Handling of the byte as if no sequence were open.
   always_comb begin
      fresh_emit    = 1'b1;
      fresh_pending = PEND_NONE;
      fresh_partial = '0;
      fresh_item    = '{code_point: {{(CP_W-BYTE_W){1'b0}}, in_byte},
                        is_error: 1'b0, last: 1'b1};
      if (in_byte < CONT_BASE) begin
         fresh_emit = 1'b1;
      end else if (in_byte < LEAD2_BASE) begin
         fresh_item = '{code_point: REPLACEMENT, is_error: 1'b1, last: 1'b1};
      end else if (in_byte < LEAD3_BASE) begin
         fresh_emit    = 1'b0;
         fresh_pending = PEND_ONE;
         fresh_partial = {{(CP_W-5){1'b0}}, in_byte[4:0]};
      end else if (in_byte < LEAD4_BASE) begin
         fresh_emit    = 1'b0;
         fresh_pending = PEND_TWO;
         fresh_partial = {{(CP_W-4){1'b0}}, in_byte[3:0]};
      end else if (in_byte < LEAD_LIMIT) begin
         fresh_emit    = 1'b0;
         fresh_pending = PEND_THREE;
         fresh_partial = {{(CP_W-3){1'b0}}, in_byte[2:0]};
      end else begin
         fresh_item = '{code_point: REPLACEMENT, is_error: 1'b1, last: 1'b1};
      end
   end

   assign is_cont = (in_byte & CONT_MASK) == CONT_BASE;
   assign joined  = {partial[CP_W-7:0], in_byte[5:0]};

   always_comb begin
      error_item  = '{code_point: REPLACEMENT, is_error: 1'b1, last: !fresh_emit};
      push.count  = 2'd0;
      push.first  = fresh_item;
      push.second = fresh_item;
      pending_in  = fresh_pending;
      partial_in  = fresh_partial;
      if (pending != PEND_NONE && is_cont) begin
         if (pending == PEND_ONE) begin
            push.count = 2'd1;
            push.first = '{code_point: joined, is_error: 1'b0, last: 1'b1};
            pending_in = PEND_NONE;
            partial_in = '0;
         end else begin
            pending_in = pending - 2'd1;
            partial_in = joined;
         end
      end else if (pending != PEND_NONE) begin
         // Interrupted sequence: report it, then treat the byte as a fresh one.
         push.count  = fresh_emit ? 2'd2 : 2'd1;
         push.first  = error_item;
         push.second = fresh_item;
      end else begin
         push.count = {1'b0, fresh_emit};
      end
   end

endmodule

`default_nettype wire

### rtl/utf8d_rsp_fifo.sv
`default_nettype none

module utf8d_rsp_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_en,
   input  wire utf8d_pkg::rsp_push_type push,
   input  wire logic                    pop,
   output logic                         room,
   output logic                         out_valid,
   output utf8d_pkg::rsp_item_type      out_item
);
   import utf8d_pkg::*;

   rsp_item_type         entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [1:0]           push_n;
   logic                 pop_en;

   assign push_n    = push_en ? push.count : 2'd0;
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop_en    = pop && out_valid;
   // Room for the two results that one byte can cause.
   assign room      = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop_en);
   assign count_in  = count_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(pop_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

### rtl/utf8_stream_decoder_top.sv
// Permissive UTF-8 decoder, one byte per item.
// req_bus carries one raw byte (in_byte) per item; rsp_bus carries decoded
// results (code_point, is_error, last). A byte gives zero, one or two
// results; last marks the final result of the byte. Errors carry 0xFFFD.
// A result passes through the input register and then the decode into
// the four-entry result queue before it is offered.
// Throughput: one byte per cycle while the result queue has room; the
// result channel moves one item per cycle while the receiver is ready.
// The decode itself has no loop and no multi-cycle unit.
// Reset empties the input register and result queue and closes any open
// sequence; req_bus.ready is high in the first cycle after reset.
// When the receiver stalls, results wait in the queue; bytes are still
// taken while it has room for two more results, so the input side stalls
// once three results wait in the queue and the input register holds a byte.
`default_nettype none

module utf8_stream_decoder_top (
   input wire logic    clock,
   input wire logic    reset,
   utf8d_req_if.sink   req_bus,
   utf8d_rsp_if.source rsp_bus
);
   import utf8d_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [1:0]        pending_ff, pending_in;
   logic [CP_W-1:0]   partial_ff, partial_in;
   logic              room;
   logic              advance;
   logic              req_accept;
   rsp_push_type      push;
   rsp_item_type      out_item;

   assign advance        = in_valid_ff && room;
   assign req_bus.ready  = !in_valid_ff || advance;
   assign req_accept     = req_bus.valid && req_bus.ready;
   assign in_valid_in    = req_accept || (in_valid_ff && !advance);

   utf8d_decode u_decode (
      .in_byte    (in_byte_ff),
      .pending    (pending_ff),
      .partial    (partial_ff),
      .push       (push),
      .pending_in (pending_in),
      .partial_in (partial_in)
   );

   utf8d_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push      (push),
      .pop       (rsp_bus.ready),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_item  (out_item)
   );

   assign rsp_bus.code_point = out_item.code_point;
   assign rsp_bus.is_error   = out_item.is_error;
   assign rsp_bus.last       = out_item.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff  <= PEND_NONE;
         partial_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_bus.in_byte;
      end
   end

endmodule

`default_nettype wire

### rtl/utf8d_checker.sv
`default_nettype none

module utf8d_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [utf8d_pkg::CP_W-1:0]   rsp_code_point,
   input wire logic                         rsp_is_error
);
   import utf8d_pkg::*;

   // Reset leaves the result queue empty and the input register free.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready right after reset");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_error |-> rsp_code_point == REPLACEMENT)
      else $error("error result without replacement code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_utf8d_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_code_point (rsp_bus.code_point),
   .rsp_is_error   (rsp_bus.is_error)
);

`default_nettype wire

### tb/utf8d_stream_checker.sv
`default_nettype none

module utf8d_stream_checker
   import utf8d_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   utf8d_req_if     req_mon,
   utf8d_rsp_if     rsp_mon,
   output int       fail_count,
   output int       pending_results,
   output int       bytes_seen,
   output int       results_seen,
   output int       error_results,
   output int       multibyte_points,
   output int       broken_sequences
);

   // Decoder state as the stream has been seen so far.
   logic [1:0]      cont_left;
   logic [CP_W-1:0] cp_bits;
   rsp_item_type    expected_cp_q [$];
   rsp_item_type    oldest;

   function automatic rsp_item_type make_result(input logic [CP_W-1:0] cp, input logic err);
      rsp_item_type r;
      r.code_point = cp;
      r.is_error   = err;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      rsp_item_type outs [$];
      logic         no_sequence;
      no_sequence = (cont_left == PEND_NONE);
      if (!no_sequence) begin
         if ((b & CONT_MASK) == CONT_BASE) begin
            cp_bits   = {cp_bits[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == PEND_NONE) begin
               outs.push_back(make_result(cp_bits, 1'b0));
               cp_bits = '0;
               multibyte_points++;
            end
         end else begin
            // The open sequence is dropped and this byte is decoded as if no sequence were open.
            outs.push_back(make_result(REPLACEMENT, 1'b1));
            cont_left   = PEND_NONE;
            cp_bits     = '0;
            no_sequence = 1'b1;
            broken_sequences++;
         end
      end
      if (no_sequence) begin
         if (b < CONT_BASE) begin
            outs.push_back(make_result(CP_W'(b), 1'b0));
         end else if (b < LEAD2_BASE) begin
            outs.push_back(make_result(REPLACEMENT, 1'b1));
         end else if (b < LEAD3_BASE) begin
            cp_bits   = CP_W'(b[4:0]);
            cont_left = PEND_ONE;
         end else if (b < LEAD4_BASE) begin
            cp_bits   = CP_W'(b[3:0]);
            cont_left = PEND_TWO;
         end else if (b < LEAD_LIMIT) begin
            cp_bits   = CP_W'(b[2:0]);
            cont_left = PEND_THREE;
         end else begin
            outs.push_back(make_result(REPLACEMENT, 1'b1));
         end
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) expected_cp_q.push_back(outs[i]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cont_left = PEND_NONE;
         cp_bits   = '0;
         expected_cp_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (rsp_mon.is_error) error_results++;
            if (expected_cp_q.size() == 0) begin
               $error("result with none expected: code_point %h is_error %b last %b",
                      rsp_mon.code_point, rsp_mon.is_error, rsp_mon.last);
               fail_count++;
            end else begin
               oldest = expected_cp_q.pop_front();
               if (rsp_mon.code_point !== oldest.code_point) begin
                  $error("code_point: expected %h, got %h", oldest.code_point,
                         rsp_mon.code_point);
                  fail_count++;
               end
               if (rsp_mon.is_error !== oldest.is_error) begin
                  $error("is_error: expected %b, got %b", oldest.is_error, rsp_mon.is_error);
                  fail_count++;
               end
               if (rsp_mon.last !== oldest.last) begin
                  $error("last: expected %b, got %b", oldest.last, rsp_mon.last);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            bytes_seen++;
            decode_byte(req_mon.in_byte);
         end
      end
      pending_results = expected_cp_q.size();
   end

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
   import utf8d_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_LEN     = 80;
   localparam int PHASE_ITEMS  = 180;
   localparam int NUM_PHASES   = 4;

   logic clock;
   logic reset;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int quiet_cycles;

   int fail_count;
   int pending_results;
   int bytes_seen;
   int results_seen;
   int error_results;
   int multibyte_points;
   int broken_sequences;

   // Extremes, stray and invalid bytes, each sequence length, and interrupted sequences.
   logic [BYTE_W-1:0] directed_bytes [24] = '{
      8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
      8'hC2, 8'h80,
      8'hEF, 8'hBF, 8'hBF,
      8'hF7, 8'hBF, 8'hBF, 8'hBF,
      8'hC3, 8'h41,
      8'hE2, 8'h82, 8'hE2, 8'h82, 8'hAC,
      8'hF0, 8'hFF
   };

   int phase_idle  [NUM_PHASES] = '{0, 72, 0, 21};
   int phase_stall [NUM_PHASES] = '{0, 0, 72, 21};

   utf8d_req_if req_if ();
   utf8d_rsp_if rsp_if ();

   utf8_stream_decoder_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   utf8d_stream_checker stream_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .bytes_seen       (bytes_seen),
      .results_seen     (results_seen),
      .error_results    (error_results),
      .multibyte_points (multibyte_points),
      .broken_sequences (broken_sequences)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("Timed out after %0d cycles with no item moving.", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Mostly well-formed characters with random payload; some truncated
   // sequences and some raw noise bytes.
   task automatic send_char(output int sent);
      logic [BYTE_W-1:0] seq [$];
      int                kind;
      int                conts;
      kind = $urandom_range(99);
      if (kind < 25) begin
         seq.push_back(BYTE_W'($urandom_range(8'h7F)));
      end else if (kind < 85) begin
         conts = $urandom_range(3, 1);
         case (conts)
            1: seq.push_back({3'b110, 5'($urandom)});
            2: seq.push_back({4'b1110, 4'($urandom)});
            default: seq.push_back({5'b11110, 3'($urandom)});
         endcase
         if (kind >= 75) conts = $urandom_range(conts - 1, 0);
         repeat (conts) seq.push_back({2'b10, 6'($urandom)});
      end else begin
         seq.push_back(BYTE_W'($urandom));
      end
      foreach (seq[i]) push_byte(seq[i]);
      sent = seq.size();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int sent;
      int phase_count;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 0;
      quiet_cycles   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
      wait_drained();

      // Receiver holds off while the sender keeps offering items, so the
      // result queue fills and the input side stalls.
      hold_cycles = HOLD_LEN;
      phase_count = 0;
      while (phase_count < 40) begin
         send_char(sent);
         phase_count += sent;
      end
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct  = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         phase_count    = 0;
         while (phase_count < PHASE_ITEMS) begin
            send_char(sent);
            phase_count += sent;
         end
         wait_drained();
      end

      $display("Fed %0d bytes, checked %0d results: %0d errors,", bytes_seen, results_seen,
               error_results);
      $display("%0d multi-byte code points, %0d interrupted sequences.", multibyte_points,
               broken_sequences);
      $display("Traffic ran with no gaps, sender gaps, receiver stalls, both, and a %0d-cycle hold.",
               HOLD_LEN);
      if (fail_count == 0 && pending_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

### utf8_stream_decoder_top.f
rtl/utf8d_pkg.sv
rtl/utf8d_req_if.sv
rtl/utf8d_rsp_if.sv
rtl/utf8d_decode.sv
rtl/utf8d_rsp_fifo.sv
rtl/utf8_stream_decoder_top.sv
rtl/utf8d_checker.sv
tb/utf8d_stream_checker.sv
tb/tb.sv
